>>> sv/clcd_pkg.sv
// package for the character lcd nibble writer: payload beats, codes, sequencer states
// and the small constant tables (init bytes, line base addresses)
// depends on nothing; used by char_lcd_nibble_writer_core and its checker
`default_nettype none

package clcd_pkg;

   // request codes
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_INIT     = 3'd1;
   localparam logic [2:0] CMD_COMMAND  = 3'd2;
   localparam logic [2:0] CMD_DATA     = 3'd3;
   localparam logic [2:0] CMD_POSITION = 3'd4;

   // register indexes
   localparam logic [2:0] REG_ENABLE_LOW = 3'd0;
   localparam logic [2:0] REG_NIBBLE_GAP = 3'd1;
   localparam logic [2:0] REG_SETTLE     = 3'd2;
   localparam logic [2:0] REG_POWER_UP   = 3'd3;
   localparam logic [2:0] REG_INIT_END   = 3'd4;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned WaitWidth     = 16;

   localparam logic [7:0]  ENABLE_LOW_RESET = 8'd1;
   localparam logic [15:0] NIBBLE_GAP_RESET = 16'd200;
   localparam logic [15:0] SETTLE_RESET     = 16'd2000;
   localparam logic [15:0] POWER_UP_RESET   = 16'd20000;
   localparam logic [15:0] INIT_END_RESET   = 16'd2000;

   localparam logic [2:0] INIT_BYTES  = 3'd5;
   localparam logic [7:0] MAX_COLUMN  = 8'd19;
   localparam logic [2:0] FIRST_LINE  = 3'd1;
   localparam logic [2:0] LAST_LINE   = 3'd4;

   typedef enum logic [8:0] {
      PH_IDLE     = 9'b000000001,
      PH_PWRUP    = 9'b000000010,
      PH_HI_SETUP = 9'b000000100,
      PH_HI_LOW   = 9'b000001000,
      PH_HI_GAP   = 9'b000010000,
      PH_LO_SETUP = 9'b000100000,
      PH_LO_LOW   = 9'b001000000,
      PH_SETTLE   = 9'b010000000,
      PH_INIT_END = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] byte_value;
      logic [2:0] line_number;
      logic [7:0] column;
   } req_type;

   typedef struct packed {
      logic       rs_pin;
      logic       en_pin;
      logic [3:0] bus_nibble;
      logic       busy_res;
      logic       accepted;
   } rsp_type;

   // power-on command sequence for the 4-bit interface
   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      case (step)
         3'd0:    b = 8'h02;
         3'd1:    b = 8'h28;
         3'd2:    b = 8'h0C;
         3'd3:    b = 8'h06;
         3'd4:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // ddram address of column 0 for lines 1..4
   function automatic logic [7:0] line_base(input logic [1:0] line_idx);
      logic [7:0] b;
      case (line_idx)
         2'd0:    b = 8'h80;
         2'd1:    b = 8'hC0;
         2'd2:    b = 8'h94;
         default: b = 8'hD4;
      endcase
      return b;
   endfunction

   // a duration of n ticks loads n-1; zero behaves as one tick
   function automatic logic [15:0] span_ticks(input logic [15:0] ticks);
      return (ticks == 16'd0) ? 16'd0 : ticks - 16'd1;
   endfunction

endpackage

`default_nettype wire

>>> sv/char_lcd_nibble_writer_core.sv
// top level of the character lcd nibble writer (4-bit bus sequencer)
// depends on clcd_pkg for payload types, codes, states and tables
`default_nettype none

// each response beat is registered and appears in the cycle after its accepted request beat
// one request beat per cycle unless a response stalls; each beat is one sequencer tick
// the response register frees itself in the cycle it is taken, so ready stays high then
// reset (synchronous, active high): sequencer idle, enable high, rs and bus low,
// timing registers back to their defaults, response register empty
module char_lcd_nibble_writer_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire clcd_pkg::req_type                  req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      clcd_pkg::rsp_type                  rsp_data,
   input  wire logic                               csr_write,
   input  wire logic [clcd_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [clcd_pkg::CsrDataWidth-1:0]  csr_wdata
);

   // timing registers
   logic [7:0]  enable_low_ff;
   logic [15:0] nibble_gap_ff;
   logic [15:0] settle_ff;
   logic [15:0] power_up_ff;
   logic [15:0] init_end_ff;

   // sequencer state
   clcd_pkg::phase_type           phase_ff, phase_in;
   logic [clcd_pkg::WaitWidth-1:0] wait_ff, wait_in;
   logic [7:0]                    pending_ff, pending_in;
   logic [2:0]                    init_step_ff, init_step_in;
   logic                          init_active_ff, init_active_in;
   logic                          rs_ff, rs_in;
   logic                          en_ff, en_in;
   logic [3:0]                    nibble_ff, nibble_in;
   logic                          accepted_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   clcd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // byte launch request from the decoder or the init sequencer
   logic       start_req;
   logic [7:0] start_val;
   logic       start_rs;
   logic [2:0] step_next;
   logic [2:0] line_m1;
   logic       pos_ok;
   logic       req_beat;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // set position is taken only for lines 1..4 and columns 0..19
   assign line_m1 = req_data.line_number - 3'd1;
   assign pos_ok  = (req_data.column <= clcd_pkg::MAX_COLUMN)
                 && (req_data.line_number >= clcd_pkg::FIRST_LINE)
                 && (req_data.line_number <= clcd_pkg::LAST_LINE);
   assign step_next = init_step_ff + 3'd1;

   // timing registers; a new value is picked up when the next wait is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_low_ff <= clcd_pkg::ENABLE_LOW_RESET;
         nibble_gap_ff <= clcd_pkg::NIBBLE_GAP_RESET;
         settle_ff     <= clcd_pkg::SETTLE_RESET;
         power_up_ff   <= clcd_pkg::POWER_UP_RESET;
         init_end_ff   <= clcd_pkg::INIT_END_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            clcd_pkg::REG_ENABLE_LOW: enable_low_ff <= csr_wdata[7:0];
            clcd_pkg::REG_NIBBLE_GAP: nibble_gap_ff <= csr_wdata;
            clcd_pkg::REG_SETTLE:     settle_ff     <= csr_wdata;
            clcd_pkg::REG_POWER_UP:   power_up_ff   <= csr_wdata;
            clcd_pkg::REG_INIT_END:   init_end_ff   <= csr_wdata;
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   // one sequencer step per request beat
   always_comb begin
      phase_in       = phase_ff;
      wait_in        = wait_ff;
      pending_in     = pending_ff;
      init_step_in   = init_step_ff;
      init_active_in = init_active_ff;
      rs_in          = rs_ff;
      en_in          = en_ff;
      nibble_in      = nibble_ff;
      accepted_in    = 1'b0;
      start_req      = 1'b0;
      start_val      = req_data.byte_value;
      start_rs       = 1'b0;

      if (phase_ff == clcd_pkg::PH_IDLE) begin
         // idle: decode the request, no wait advances on this tick
         unique case (req_data.cmd)
            clcd_pkg::CMD_INIT: begin
               en_in          = 1'b1;
               init_active_in = 1'b1;
               init_step_in   = 3'd0;
               phase_in       = clcd_pkg::PH_PWRUP;
               wait_in        = clcd_pkg::span_ticks(power_up_ff);
               accepted_in    = 1'b1;
            end
            clcd_pkg::CMD_COMMAND: begin
               start_req   = 1'b1;
               accepted_in = 1'b1;
            end
            clcd_pkg::CMD_DATA: begin
               start_req   = 1'b1;
               start_rs    = 1'b1;
               accepted_in = 1'b1;
            end
            clcd_pkg::CMD_POSITION: begin
               if (pos_ok) begin
                  start_req   = 1'b1;
                  start_val   = clcd_pkg::line_base(line_m1[1:0]) | req_data.column;
                  accepted_in = 1'b1;
               end
            end
            default: ;  // tick only and spare codes start nothing
         endcase
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - 16'd1;
      end else begin
         unique case (phase_ff)
            clcd_pkg::PH_PWRUP: begin
               init_step_in = 3'd0;
               start_req    = 1'b1;
               start_val    = clcd_pkg::init_byte(3'd0);
            end
            clcd_pkg::PH_HI_SETUP: begin
               en_in    = 1'b0;
               phase_in = clcd_pkg::PH_HI_LOW;
               wait_in  = clcd_pkg::span_ticks({8'd0, enable_low_ff});
            end
            clcd_pkg::PH_HI_LOW: begin
               en_in    = 1'b1;
               phase_in = clcd_pkg::PH_HI_GAP;
               wait_in  = clcd_pkg::span_ticks(nibble_gap_ff);
            end
            clcd_pkg::PH_HI_GAP: begin
               nibble_in = pending_ff[3:0];
               phase_in  = clcd_pkg::PH_LO_SETUP;
               wait_in   = '0;
            end
            clcd_pkg::PH_LO_SETUP: begin
               en_in    = 1'b0;
               phase_in = clcd_pkg::PH_LO_LOW;
               wait_in  = clcd_pkg::span_ticks({8'd0, enable_low_ff});
            end
            clcd_pkg::PH_LO_LOW: begin
               en_in    = 1'b1;
               phase_in = clcd_pkg::PH_SETTLE;
               wait_in  = clcd_pkg::span_ticks(settle_ff);
            end
            clcd_pkg::PH_SETTLE: begin
               if (init_active_ff) begin
                  init_step_in = step_next;
                  if (step_next < clcd_pkg::INIT_BYTES) begin
                     start_req = 1'b1;
                     start_val = clcd_pkg::init_byte(step_next);
                  end else if (init_end_ff == 16'd0) begin
                     // no trailing wait: straight back to idle
                     init_active_in = 1'b0;
                     phase_in       = clcd_pkg::PH_IDLE;
                  end else begin
                     phase_in = clcd_pkg::PH_INIT_END;
                     wait_in  = init_end_ff - 16'd1;
                  end
               end else begin
                  phase_in = clcd_pkg::PH_IDLE;
               end
            end
            default: begin
               // end of the trailing init wait
               init_active_in = 1'b0;
               phase_in       = clcd_pkg::PH_IDLE;
               wait_in        = '0;
            end
         endcase
      end

      // launch a byte: high nibble on the bus with enable high for one tick
      if (start_req) begin
         pending_in = start_val;
         rs_in      = start_rs;
         nibble_in  = start_val[7:4];
         en_in      = 1'b1;
         phase_in   = clcd_pkg::PH_HI_SETUP;
         wait_in    = '0;
      end
   end

   // response beat carries the pin levels after this tick
   always_comb begin
      rsp_data_in.rs_pin     = rs_in;
      rsp_data_in.en_pin     = en_in;
      rsp_data_in.bus_nibble = nibble_in;
      rsp_data_in.busy_res   = (phase_in != clcd_pkg::PH_IDLE);
      rsp_data_in.accepted   = accepted_in;
      rsp_valid_in           = req_beat || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= clcd_pkg::PH_IDLE;
         wait_ff        <= '0;
         pending_ff     <= '0;
         init_step_ff   <= '0;
         init_active_ff <= 1'b0;
         rs_ff          <= 1'b0;
         en_ff          <= 1'b1;
         nibble_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_beat) begin
            phase_ff       <= phase_in;
            wait_ff        <= wait_in;
            pending_ff     <= pending_in;
            init_step_ff   <= init_step_in;
            init_active_ff <= init_active_in;
            rs_ff          <= rs_in;
            en_ff          <= en_in;
            nibble_ff      <= nibble_in;
         end
      end
   end

   // payload register, loaded only on a request beat
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/clcd_checker.sv
// port-level checker for char_lcd_nibble_writer_core, attached by bind
// depends on clcd_pkg for the payload types
`default_nettype none

module clcd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire clcd_pkg::rsp_type rsp_data
);

   // a taken request always leaves the sequencer busy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.accepted) |-> rsp_data.busy_res)
      else $error("accepted beat without busy");

   // every request beat yields a response beat in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("request beat without response");

   // an empty response register never stalls the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("ready low with empty response register");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // nothing is presented right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind char_lcd_nibble_writer_core clcd_checker u_clcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
